// File: hw/rtl/bads_pkg.sv
// Shared constants, codes and types for the bridge converter serial reader.
`default_nettype none
package bads_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned MaxAverage = 256;
  localparam int unsigned TareW      = 24;
  localparam int unsigned CntW       = $clog2(MaxAverage + 1);
  localparam int unsigned SumW       = 34;
  localparam int unsigned ResW       = 25;
  localparam int unsigned BitCntW    = $clog2(SampleBits + 1);
  localparam int unsigned PulseW     = 2;
  localparam int unsigned StepW      = $clog2(SumW + 1);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXTRA_PULSES  = 2'd0,
    CFG_AVERAGE_COUNT = 2'd1,
    CFG_TARE_OFFSET   = 2'd2
  } cfg_idx_e;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_WAIT = 6'b000010,
    PH_BHI  = 6'b000100,
    PH_BLO  = 6'b001000,
    PH_PHI  = 6'b010000,
    PH_PLO  = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    SEQ_TICK = 3'b001,
    SEQ_LOAD = 3'b010,
    SEQ_DIV  = 3'b100
  } seq_e;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/bads_divider.sv
// Bit-serial restoring divider: unsigned magnitude by sample count, one bit a cycle.
`default_nettype none
module bads_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bads_pkg::div_req_t req_i,
  output bads_pkg::div_rsp_t     rsp_o
);

  logic [bads_pkg::SumW-1:0]    quo_q;
  logic [bads_pkg::CntW-1:0]    rem_q;
  logic [bads_pkg::CntW-1:0]    div_q;
  logic [bads_pkg::StepW-1:0]   step_q;
  logic                         busy_q;
  logic                         done_q;

  logic [bads_pkg::CntW:0]      trial;
  logic [bads_pkg::CntW:0]      diff;
  logic                         take;
  logic [bads_pkg::CntW-1:0]    rem_d;
  logic [bads_pkg::SumW-1:0]    quo_d;
  logic                         last;

  always_comb begin
    trial = {rem_q, quo_q[bads_pkg::SumW-1]};
    diff  = trial - {1'b0, div_q};
    take  = (trial >= {1'b0, div_q});
    rem_d = take ? diff[bads_pkg::CntW-1:0] : trial[bads_pkg::CntW-1:0];
    quo_d = {quo_q[bads_pkg::SumW-2:0], take};
    last  = busy_q && (step_q == bads_pkg::StepW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= last && !req_i.start;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= bads_pkg::StepW'(bads_pkg::SumW);
      end else if (busy_q) begin
        step_q <= step_q - bads_pkg::StepW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

// File: hw/rtl/bridge_adc_serial_reader.sv
// Top level: tick-level two-wire master for a bridge converter, with averaging.
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid/in_ready    | data_level, start_req
//  out     | out       | out_valid/out_ready  | clock_level, busy_res, result_valid,
//          |           |                      | result_value
//  cfg     | in        | cfg_we (no wait)     | cfg_idx, cfg_data
//
// A tick transfer that does not finish a reading loads the output register directly.
// The tick that finishes a reading goes through the transfer, an abs step, the bit-serial
// divider and a done step that loads the output register.
// Reset clears the tick phase, counters and sum, sets config registers to their defaults
// and arms discard.
// A waiting result in the output register holds off the next tick transfer only
// until it is taken; the two can transfer at the same edge.
`default_nettype none
module bridge_adc_serial_reader (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              data_level_i,
  input  wire logic                              start_req_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   clock_level_o,
  output logic                                   busy_res_o,
  output logic                                   result_valid_o,
  output logic signed [bads_pkg::ResW-1:0]       result_value_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [bads_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [bads_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [bads_pkg::PulseW-1:0]      extra_q;
  logic [bads_pkg::CntW-1:0]        avg_q;
  logic [bads_pkg::TareW-1:0]       tare_q;

  bads_pkg::phase_e                 phase_q, phase_d;
  bads_pkg::seq_e                   seq_q, seq_d;
  logic [bads_pkg::BitCntW-1:0]     bit_cnt_q, bit_cnt_d;
  logic [bads_pkg::PulseW-1:0]      pulse_q, pulse_d;
  logic [bads_pkg::SampleBits-1:0]  shift_q, shift_d;
  logic                             disc_q, disc_d;
  logic [bads_pkg::CntW-1:0]        smp_q, smp_d;
  logic [bads_pkg::SumW-1:0]        sum_q, sum_d;
  logic                             clk_out_q, clk_out_d;
  logic                             neg_q;

  logic                             out_valid_q;
  logic                             out_clk_q, out_busy_q, out_rv_q;
  logic [bads_pkg::ResW-1:0]        out_val_q;

  logic                             in_fire;
  logic                             finish;
  logic                             tick_load;
  logic                             res_load;
  logic [bads_pkg::PulseW-1:0]      pulses_want;
  logic [bads_pkg::CntW-1:0]        count_want;
  logic [bads_pkg::SumW-1:0]        sample_ext;
  logic [bads_pkg::SumW-1:0]        tare_ext;
  logic [bads_pkg::ResW-1:0]        quo_res;
  logic [bads_pkg::ResW-1:0]        res_val;

  bads_pkg::div_req_t               div_req;
  bads_pkg::div_rsp_t               div_rsp;

  assign pulses_want = (extra_q == '0) ? bads_pkg::PulseW'(1) : extra_q;
  assign count_want  = (avg_q == '0) ? bads_pkg::CntW'(1) :
                       (avg_q > bads_pkg::CntW'(bads_pkg::MaxAverage)) ?
                       bads_pkg::CntW'(bads_pkg::MaxAverage) : avg_q;
  assign sample_ext  = {{(bads_pkg::SumW - bads_pkg::SampleBits){shift_q[bads_pkg::SampleBits-1]}},
                        shift_q};
  assign tare_ext    = {{(bads_pkg::SumW - bads_pkg::TareW){tare_q[bads_pkg::TareW-1]}}, tare_q};

  assign in_ready_o = (seq_q == bads_pkg::SEQ_TICK) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d   = phase_q;
    seq_d     = seq_q;
    bit_cnt_d = bit_cnt_q;
    pulse_d   = pulse_q;
    shift_d   = shift_q;
    disc_d    = disc_q;
    smp_d     = smp_q;
    sum_d     = sum_q;
    clk_out_d = clk_out_q;
    finish    = 1'b0;
    tick_load = 1'b0;
    res_load  = 1'b0;

    case (seq_q)
      bads_pkg::SEQ_TICK: begin
        if (in_fire) begin
          case (phase_q)
            bads_pkg::PH_IDLE: begin
              clk_out_d = 1'b0;
              if (start_req_i) begin
                smp_d   = '0;
                sum_d   = '0;
                phase_d = bads_pkg::PH_WAIT;
              end
            end
            bads_pkg::PH_WAIT: begin
              if (!data_level_i) begin
                bit_cnt_d = '0;
                shift_d   = '0;
                clk_out_d = 1'b1;
                phase_d   = bads_pkg::PH_BHI;
              end else begin
                clk_out_d = 1'b0;
              end
            end
            bads_pkg::PH_BHI: begin
              shift_d   = {shift_q[bads_pkg::SampleBits-2:0], data_level_i};
              bit_cnt_d = bit_cnt_q + bads_pkg::BitCntW'(1);
              clk_out_d = 1'b0;
              phase_d   = bads_pkg::PH_BLO;
            end
            bads_pkg::PH_BLO: begin
              clk_out_d = 1'b1;
              if (bit_cnt_q < bads_pkg::BitCntW'(bads_pkg::SampleBits)) begin
                phase_d = bads_pkg::PH_BHI;
              end else begin
                pulse_d = '0;
                phase_d = bads_pkg::PH_PHI;
              end
            end
            bads_pkg::PH_PHI: begin
              pulse_d   = pulse_q + bads_pkg::PulseW'(1);
              clk_out_d = 1'b0;
              phase_d   = bads_pkg::PH_PLO;
            end
            bads_pkg::PH_PLO: begin
              if (pulse_q < pulses_want) begin
                clk_out_d = 1'b1;
                phase_d   = bads_pkg::PH_PHI;
              end else begin
                clk_out_d = 1'b0;
                if (disc_q) begin
                  disc_d  = 1'b0;
                  phase_d = bads_pkg::PH_WAIT;
                end else begin
                  sum_d = sum_q + sample_ext - tare_ext;
                  smp_d = smp_q + bads_pkg::CntW'(1);
                  if (smp_d >= count_want) begin
                    phase_d = bads_pkg::PH_IDLE;
                    finish  = 1'b1;
                  end else begin
                    phase_d = bads_pkg::PH_WAIT;
                  end
                end
              end
            end
            default: begin
              phase_d = bads_pkg::PH_IDLE;
            end
          endcase
          if (finish) begin
            seq_d = bads_pkg::SEQ_LOAD;
          end else begin
            tick_load = 1'b1;
          end
        end
      end
      bads_pkg::SEQ_LOAD: begin
        seq_d = bads_pkg::SEQ_DIV;
      end
      bads_pkg::SEQ_DIV: begin
        if (div_rsp.done) begin
          res_load = 1'b1;
          seq_d    = bads_pkg::SEQ_TICK;
        end
      end
      default: begin
        seq_d = bads_pkg::SEQ_TICK;
      end
    endcase

    if (cfg_we_i && (cfg_idx_i == bads_pkg::CFG_EXTRA_PULSES)) begin
      disc_d = 1'b1;
    end
  end

  assign div_req.start    = (seq_q == bads_pkg::SEQ_LOAD);
  assign div_req.dividend = sum_q[bads_pkg::SumW-1] ? (~sum_q + bads_pkg::SumW'(1)) : sum_q;
  assign div_req.divisor  = smp_q;

  bads_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign quo_res = div_rsp.quotient[bads_pkg::ResW-1:0];
  assign res_val = neg_q ? (~quo_res + bads_pkg::ResW'(1)) : quo_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_q     <= bads_pkg::PulseW'(1);
      avg_q       <= bads_pkg::CntW'(1);
      tare_q      <= '0;
      phase_q     <= bads_pkg::PH_IDLE;
      seq_q       <= bads_pkg::SEQ_TICK;
      bit_cnt_q   <= '0;
      pulse_q     <= '0;
      shift_q     <= '0;
      disc_q      <= 1'b1;
      smp_q       <= '0;
      sum_q       <= '0;
      clk_out_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      seq_q     <= seq_d;
      bit_cnt_q <= bit_cnt_d;
      pulse_q   <= pulse_d;
      shift_q   <= shift_d;
      disc_q    <= disc_d;
      smp_q     <= smp_d;
      sum_q     <= sum_d;
      clk_out_q <= clk_out_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bads_pkg::CFG_EXTRA_PULSES:  extra_q <= cfg_data_i[bads_pkg::PulseW-1:0];
          bads_pkg::CFG_AVERAGE_COUNT: avg_q   <= cfg_data_i[bads_pkg::CntW-1:0];
          bads_pkg::CFG_TARE_OFFSET:   tare_q  <= cfg_data_i[bads_pkg::TareW-1:0];
          default: ;
        endcase
      end
      if (tick_load || res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_req.start) begin
      neg_q <= sum_q[bads_pkg::SumW-1];
    end
    if (tick_load) begin
      out_clk_q  <= clk_out_d;
      out_busy_q <= (phase_d != bads_pkg::PH_IDLE);
      out_rv_q   <= 1'b0;
      out_val_q  <= '0;
    end else if (res_load) begin
      out_clk_q  <= clk_out_q;
      out_busy_q <= 1'b0;
      out_rv_q   <= 1'b1;
      out_val_q  <= res_val;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign clock_level_o  = out_clk_q;
  assign busy_res_o     = out_busy_q;
  assign result_valid_o = out_rv_q;
  assign result_value_o = out_val_q;

endmodule
`default_nettype wire

// File: hw/rtl/bads_checker.sv
// Port-level checker for the bridge converter serial reader, with its bind.
`default_nettype none
module bads_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_o,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  input  wire logic                              clock_level_o,
  input  wire logic                              busy_res_o,
  input  wire logic                              result_valid_o,
  input  wire logic signed [bads_pkg::ResW-1:0]  result_value_o
);

  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_valid_o |-> !busy_res_o && !clock_level_o)
    else $error("result transfer shows busy or clock high");

  a_idle_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_valid_o |-> result_value_o == '0)
    else $error("nonzero value without result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o)
      && $stable(result_valid_o))
    else $error("stalled output transfer changed");

  a_tick_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o || !in_ready_o)
    else $error("accepted tick left no output and no stall");

endmodule

bind bridge_adc_serial_reader bads_checker u_bads_checker (.*);
`default_nettype wire
